// ===== design/assert_macros.svh =====
// Assertion macros shared by the odometry RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ddo_pkg.sv =====
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [33:0] PI_Q      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629714;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_SET_ALL = 2'd1,
        ACT_SET_POS = 2'd2,
        ACT_SET_HDG = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROTATE,
        ST_MUL,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic prep;
        logic rotate;
        logic mul;
        logic update;
    } ddo_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic primed;
        logic steps_done;
    } ddo_stat_t;

    // Arctangent table, Q3.28.
    function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sd210828714;
            5'd1:  v = 34'sd124459457;
            5'd2:  v = 34'sd65760959;
            5'd3:  v = 34'sd33381290;
            5'd4:  v = 34'sd16755422;
            5'd5:  v = 34'sd8385879;
            5'd6:  v = 34'sd4193963;
            5'd7:  v = 34'sd2097109;
            5'd8:  v = 34'sd1048571;
            5'd9:  v = 34'sd524287;
            5'd29: v = 34'sd0;
            default: v = 34'sd1 <<< (5'd28 - i);
        endcase
        return v;
    endfunction

    // Single wrap into (-pi, pi] followed by a clamp.
    function automatic logic signed [30:0] wrap_heading(input logic signed [33:0] h);
        logic signed [33:0] w;
        w = h;
        if (w > PI_Q) begin
            w = w - TWO_PI_Q;
        end
        else if (w <= -PI_Q) begin
            w = w + TWO_PI_Q;
        end
        if (w > PI_Q) begin
            w = PI_Q;
        end
        if (w <= -PI_Q) begin
            w = -PI_Q + 34'sd1;
        end
        return w[30:0];
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end
        else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/ddo_ctrl.sv =====
`default_nettype none
module ddo_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire ddo_pkg::ddo_stat_t stat,
    output ddo_pkg::ddo_cmd_t      cmd
);
    import ddo_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    if (action != ACT_SAMPLE) begin
                        cmd.load   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else begin
                        state_next = stat.primed ? ST_PREP : ST_OUT;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                cmd.rotate = 1'b1;
                if (stat.steps_done) begin
                    cmd.rotate = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while result waits")
    `ASSERT_NEXT(a_load_out, clk, rst_n, cmd.load, out_valid, "load did not report at once")

endmodule
`default_nettype wire

// ===== design/ddo_dp.sv =====
`default_nettype none
module ddo_dp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ddo_pkg::ddo_cmd_t  cmd,
    output ddo_pkg::ddo_stat_t      stat,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] left_count,
    input  wire logic signed [31:0] right_count,
    input  wire logic signed [31:0] new_x,
    input  wire logic signed [31:0] new_y,
    input  wire logic signed [30:0] new_heading,
    input  wire logic [31:0]        distance_per_count,
    input  wire logic [31:0]        radians_per_count,
    output logic signed [31:0]      pose_x,
    output logic signed [31:0]      pose_y,
    output logic signed [30:0]      pose_heading
);
    import ddo_pkg::*;

    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [30:0] head_reg;
    logic               primed_reg;
    logic [31:0]        prev_l_reg, prev_r_reg;
    logic signed [32:0] sum_reg, dif_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [54:0]        dist_reg;
    logic               dneg_reg;
    logic [58:0]        pxh_reg, pyh_reg;
    logic [59:0]        pxl_reg, pyl_reg;
    logic signed [34:0] hstep_reg;

    // Sample deltas, computed combinationally from the held input.
    logic [31:0]        rc, dl32, dr32;
    logic signed [32:0] dl, dr;
    assign rc   = 32'd0 - right_count;
    assign dl32 = left_count - prev_l_reg;
    assign dr32 = rc - prev_r_reg;
    assign dl   = {dl32[31], dl32};
    assign dr   = {dr32[31], dr32};

    // CORDIC step terms.
    logic signed [33:0] xs, ys, at;
    logic [4:0]         idx;
    assign idx = 5'(step_reg);
    assign xs  = cx_reg >>> step_reg;
    assign ys  = cy_reg >>> step_reg;
    assign at  = atan_q28(idx);

    // Magnitudes for the multiplies.
    logic [32:0] sum_abs, dif_abs;
    logic [64:0] dm, hm;
    assign sum_abs = sum_reg[32] ? 33'(-sum_reg) : 33'(sum_reg);
    assign dif_abs = dif_reg[32] ? 33'(-dif_reg) : 33'(dif_reg);

    // Heading step magnitude. Any step of 2^32 or more ends clamped after the
    // single wrap, so it is held at 2^32 to keep the update path narrow.
    logic [32:0] hmag;
    assign hmag = (|hm[64:36]) ? 33'h1_0000_0000 : {1'b0, hm[35:4]};

    // Pose update terms: magnitude of travel times cos/sin magnitude. The travel
    // is split at bit 28 and the two partial products are recombined with
    // truncation toward zero.
    logic signed [33:0] c_f, s_f;
    logic [31:0]        c_abs, s_abs;
    logic [60:0]        rx, ry;
    logic [57:0]        qx_full, qy_full;
    logic [34:0]        qx, qy;
    logic signed [34:0] nx, ny;
    assign c_f     = flip_reg ? -cx_reg : cx_reg;
    assign s_f     = flip_reg ? -cy_reg : cy_reg;
    assign c_abs   = c_f[33] ? 32'(-c_f) : 32'(c_f);
    assign s_abs   = s_f[33] ? 32'(-s_f) : 32'(s_f);
    assign rx      = 61'({pxh_reg[1:0], 28'd0}) + 61'(pxl_reg);
    assign ry      = 61'({pyh_reg[1:0], 28'd0}) + 61'(pyl_reg);
    assign qx_full = 58'(pxh_reg >> 2) + 58'(rx >> 30);
    assign qy_full = 58'(pyh_reg >> 2) + 58'(ry >> 30);
    // A move of 2^33 or more saturates the position either way.
    assign qx      = (|qx_full[57:33]) ? 35'h2_0000_0000 : 35'(qx_full[32:0]);
    assign qy      = (|qy_full[57:33]) ? 35'h2_0000_0000 : 35'(qy_full[32:0]);
    assign nx      = (dneg_reg ^ c_f[33]) ? -$signed(qx) : $signed(qx);
    assign ny      = (dneg_reg ^ s_f[33]) ? -$signed(qy) : $signed(qy);

    assign dm = 65'(sum_abs) * 65'(distance_per_count);
    assign hm = 65'(dif_abs) * 65'(radians_per_count);

    // Control state: pose, primed flag and step counter.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            head_reg   <= '0;
            primed_reg <= 1'b0;
            step_reg   <= '0;
        end
        else begin
            if (cmd.capture && action == ACT_SAMPLE) begin
                primed_reg <= 1'b1;
            end
            if (cmd.load) begin
                if (action == ACT_SET_ALL || action == ACT_SET_POS) begin
                    pos_x_reg <= new_x;
                    pos_y_reg <= new_y;
                end
                if (action == ACT_SET_ALL || action == ACT_SET_HDG) begin
                    head_reg <= wrap_heading(34'(new_heading));
                end
            end
            if (cmd.prep) begin
                step_reg <= '0;
            end
            else if (cmd.rotate) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.update) begin
                pos_x_reg <= sat32(35'(pos_x_reg) + nx);
                pos_y_reg <= sat32(35'(pos_y_reg) + ny);
                head_reg  <= wrap_heading(34'(35'(head_reg) + hstep_reg));
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        if (cmd.capture && action == ACT_SAMPLE) begin
            prev_l_reg <= left_count;
            prev_r_reg <= rc;
            sum_reg    <= dl + dr;
            dif_reg    <= dr - dl;
        end
        if (cmd.prep) begin
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            dist_reg <= dm[63:9];
            dneg_reg <= sum_reg[32];
            hstep_reg <= dif_reg[32] ? -35'(hmag) : 35'(hmag);
            if (34'(head_reg) > HALF_PI_Q) begin
                cz_reg   <= 34'(head_reg) - PI_Q;
                flip_reg <= 1'b1;
            end
            else if (34'(head_reg) < -HALF_PI_Q) begin
                cz_reg   <= 34'(head_reg) + PI_Q;
                flip_reg <= 1'b1;
            end
            else begin
                cz_reg   <= 34'(head_reg);
                flip_reg <= 1'b0;
            end
        end
        else if (cmd.rotate && !stat.steps_done) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.mul) begin
            pxh_reg <= 59'(dist_reg[54:28]) * 59'(c_abs);
            pxl_reg <= 60'(dist_reg[27:0]) * 60'(c_abs);
            pyh_reg <= 59'(dist_reg[54:28]) * 59'(s_abs);
            pyl_reg <= 60'(dist_reg[27:0]) * 60'(s_abs);
        end
    end

    assign stat.primed     = primed_reg;
    assign stat.steps_done = (step_reg == STEP_W'(CORDIC_STEPS));
    assign pose_x       = pos_x_reg;
    assign pose_y       = pos_y_reg;
    assign pose_heading = head_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_head_hi, clk, rst_n, 1'b1, 34'(head_reg) <= PI_Q, "heading above pi")
    `ASSERT_IMPL(a_head_lo, clk, rst_n, 1'b1, 34'(head_reg) > -PI_Q, "heading at or below -pi")
    `ASSERT_IMPL(a_prime, clk, rst_n, cmd.prep, primed_reg, "pose step before priming")

endmodule
`default_nettype wire

// ===== design/differential_drive_odometry.sv =====
`default_nettype none
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | action, left_count, right_count, new_x, new_y, new_heading
// out     | out_valid / out_ready | pose_x, pose_y, pose_heading
// cfg     | APB psel/penable      | distance_per_count (0x0), radians_per_count (0x4)
//
// Loads and the first sample go from IDLE straight to the result state OUT; a primed
// sample first passes PREP, the iterated CORDIC rotation in ROTATE, MUL and UPDATE.
// One item is in work at a time; in_ready is low until the result is taken.
// Reset clears the pose, the primed flag and both registers.
module differential_drive_odometry
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] left_count,
    input  wire logic signed [31:0] right_count,
    input  wire logic signed [31:0] new_x,
    input  wire logic signed [31:0] new_y,
    input  wire logic signed [30:0] new_heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pose_x,
    output logic signed [31:0]      pose_y,
    output logic signed [30:0]      pose_heading
);
    import ddo_pkg::*;

    logic [31:0] dpc_reg, rpc_reg;
    ddo_cmd_t    cmd;
    ddo_stat_t   stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dpc_reg <= '0;
            rpc_reg <= '0;
        end
        else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) begin
                dpc_reg <= pwdata;
            end
            else if (paddr == 3'd4) begin
                rpc_reg <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? dpc_reg : ((paddr == 3'd4) ? rpc_reg : 32'd0);

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddo_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .action             (action),
        .left_count         (left_count),
        .right_count        (right_count),
        .new_x              (new_x),
        .new_y              (new_y),
        .new_heading        (new_heading),
        .distance_per_count (dpc_reg),
        .radians_per_count  (rpc_reg),
        .pose_x             (pose_x),
        .pose_y             (pose_y),
        .pose_heading       (pose_heading)
    );

endmodule
`default_nettype wire

// ===== verif/differential_drive_odometry_test.sv =====
`timescale 1ns / 1ps
module differential_drive_odometry_test;
    import ddo_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_DIST = 3'd0;
    localparam logic [2:0] ADDR_RAD  = 3'd4;
    localparam longint PI_V = 843314857;
    localparam longint TWO_PI_V = 1686629714;
    localparam longint HALF_PI_V = 421657428;
    localparam longint GAIN_V = 652032874;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [30:0] h;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = '0;
    logic signed [31:0] left_count = '0, right_count = '0, new_x = '0, new_y = '0;
    logic signed [30:0] new_heading = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pose_x, pose_y;
    logic signed [30:0] pose_heading;

    // Predictor state and configuration.
    logic [31:0] dist_per_cnt = '0, rad_per_cnt = '0;
    longint odo_x = 0, odo_y = 0, odo_h = 0;
    logic [31:0] last_left = '0, last_right = '0;
    bit counts_latched = 0;

    pose_t pending_poses[$];
    int fail_count = 0;
    longint cycle_count = 0;
    bit hold_ready = 0;

    differential_drive_odometry u_top (.*);

    always #5 clk = ~clk;

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint rewrap(longint h);
        longint w;
        w = h;
        if (w > PI_V) w = w - TWO_PI_V;
        else if (w <= -PI_V) w = w + TWO_PI_V;
        if (w > PI_V) w = PI_V;
        if (w <= -PI_V) w = -PI_V + 1;
        return w;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotation-mode CORDIC giving Q1.30 cosine and sine.
    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint cx, sy, z, nx;
        bit flip;
        longint angles[30] = '{210828714, 124459457, 65760959, 33381290, 16755422,
            8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
            4, 2, 1, 0};
        cx = GAIN_V;
        sy = 0;
        z = ang;
        flip = 0;
        if (z > HALF_PI_V)
        begin
            z = z - PI_V;
            flip = 1;
        end
        else if (z < -HALF_PI_V)
        begin
            z = z + PI_V;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                z = z - angles[i];
            end
            else
            begin
                nx = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                z = z + angles[i];
            end
            cx = nx;
        end
        c = flip ? -cx : cx;
        s = flip ? -sy : sy;
    endtask

    // Travel times a Q1.30 factor, truncated toward zero.
    function automatic longint scale_q30(longint d, longint f);
        bit neg;
        logic [63:0] m, fm, hi, r, q;
        neg = (d < 0) != (f < 0);
        m = d < 0 ? -d : d;
        fm = f < 0 ? -f : f;
        hi = (m >> 28) * fm;
        r = ((hi & 64'd3) << 28) + (m & 64'h0FFFFFFF) * fm;
        q = (hi >> 2) + (r >> 30);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Advance the predicted pose for one item and queue the expected result.
    task automatic predict_pose(input action_t act, input logic [31:0] lc_in,
                                input logic [31:0] rc_in, input logic [31:0] nx,
                                input logic [31:0] ny, input logic [30:0] nh);
        logic [31:0] rc, dlu, dru;
        longint dl, dr, sum, dif, travel, hm, c, s;
        logic [63:0] dm, hmu;
        pose_t p;
        rc = 32'd0 - rc_in;
        if (act == ACT_SAMPLE)
        begin
            if (counts_latched)
            begin
                dlu = lc_in - last_left;
                dru = rc - last_right;
                dl = longint'(signed'(dlu));
                dr = longint'(signed'(dru));
                sum = dl + dr;
                dif = dr - dl;
                dm = 64'(sum < 0 ? -sum : sum) * 64'(dist_per_cnt);
                travel = longint'(dm >> 9);
                hmu = (64'(dif < 0 ? -dif : dif) * 64'(rad_per_cnt)) >> 4;
                hm = longint'(hmu);
                if (sum < 0) travel = -travel;
                rotate_unit(odo_h, c, s);
                odo_x = clamp32(odo_x + scale_q30(travel, c));
                odo_y = clamp32(odo_y + scale_q30(travel, s));
                odo_h = rewrap(odo_h + (dif < 0 ? -hm : hm));
            end
            last_left = lc_in;
            last_right = rc;
            counts_latched = 1;
        end
        else
        begin
            if (act == ACT_SET_ALL || act == ACT_SET_POS)
            begin
                odo_x = longint'(signed'(nx));
                odo_y = longint'(signed'(ny));
            end
            if (act == ACT_SET_ALL || act == ACT_SET_HDG)
                odo_h = rewrap(longint'(signed'(nh)));
        end
        p.x = odo_x[31:0];
        p.y = odo_y[31:0];
        p.h = odo_h[30:0];
        pending_poses.push_back(p);
    endtask

    // Send one item after a random gap. The task returns at the falling edge
    // after acceptance with valid still high; the next item or a drain takes
    // it from there.
    task automatic send_item(input action_t act, input logic [31:0] lc,
                             input logic [31:0] rc, input logic [31:0] nx,
                             input logic [31:0] ny, input logic [30:0] nh);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        left_count <= lc;
        right_count <= rc;
        new_x <= nx;
        new_y <= ny;
        new_heading <= nh;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_pose(act, lc, rc, nx, ny, nh);
        @(negedge clk);
    endtask

    // Wait for every queued result, then let the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_DIST) dist_per_cnt = value;
        else rad_per_cnt = value;
    endtask

    function automatic logic [30:0] rand_heading();
        return 31'($signed($urandom_range(0, 1686629713)) - 32'sd843314856);
    endfunction

    // Output side: a random wait before each result is taken, none while hold_ready is set.
    always
    begin
        int stall;
        @(negedge clk);
        stall = hold_ready ? 0 : $urandom_range(0, 11);
        if (stall != 0)
        begin
            out_ready <= 1'b0;
            repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(rst_n && out_valid)) @(posedge clk);
    end

    // Field-by-field comparison of each accepted result.
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("unexpected result x=%0d", pose_x);
                fail_count++;
            end
            else
            begin
                e = pending_poses.pop_front();
                if (pose_x !== e.x)
                begin
                    $error("pose_x expected %0d actual %0d", e.x, pose_x);
                    fail_count++;
                end
                if (pose_y !== e.y)
                begin
                    $error("pose_y expected %0d actual %0d", e.y, pose_y);
                    fail_count++;
                end
                if (pose_heading !== e.h)
                begin
                    $error("pose_heading expected %0d actual %0d", e.h, pose_heading);
                    fail_count++;
                end
            end
        end
    end

    // Loads before priming, then the priming sample and field extremes.
    task automatic test_directed();
        write_reg(ADDR_DIST, 32'h0100_0000);
        write_reg(ADDR_RAD, 32'h0040_0000);
        send_item(ACT_SET_ALL, 0, 0, 32'h7fffffff, 32'h80000000, 31'sd843314857);
        send_item(ACT_SET_HDG, 0, 0, 0, 0, -31'sd843314856);
        send_item(ACT_SET_HDG, 0, 0, 0, 0, 31'h3fffffff);
        send_item(ACT_SET_HDG, 0, 0, 0, 0, 31'h40000000);
        send_item(ACT_SET_POS, 0, 0, 32'h0001_0000, 32'hffff_0000, 0);
        send_item(ACT_SAMPLE, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'h80000000, 32'h7fffffff, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'h80000100, 32'h7ffffeff, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'h80000100, 32'h7fffff00, 0, 0, 0);
        send_item(ACT_SET_ALL, 0, 0, 32'h7fff0000, 32'h7fff0000, 31'sd200000000);
        send_item(ACT_SAMPLE, 32'h8000ffff, 32'h7fff0000, 0, 0, 0);
        send_item(ACT_SET_HDG, 0, 0, 0, 0, 31'sd843314856);
        send_item(ACT_SAMPLE, 32'h00000000, 32'h00000000, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'h00000000, 32'h80000000, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  31'h7fffffff);
        drain_results();
        write_reg(ADDR_DIST, 32'hffffffff);
        write_reg(ADDR_RAD, 32'hffffffff);
        send_item(ACT_SAMPLE, 32'h12345678, 32'h00001000, 0, 0, 0);
        send_item(ACT_SAMPLE, 32'h92345678, 32'h00000000, 0, 0, 0);
        send_item(ACT_SET_ALL, 0, 0, 32'h80000000, 32'h80000000, -31'sd843314856);
        send_item(ACT_SAMPLE, 32'h12345678, 32'h80001000, 0, 0, 0);
        drain_results();
    endtask

    // Random driving: mostly small count steps, with occasional large jumps and loads.
    task automatic test_random_drive(input int count);
        logic [31:0] l, r;
        int pick;
        l = $urandom;
        r = $urandom;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                l = l + 32'($signed($urandom_range(0, 4000)) - 2000);
                r = r + 32'($signed($urandom_range(0, 4000)) - 2000);
                send_item(ACT_SAMPLE, l, r, $urandom, $urandom, 31'($urandom));
            end
            else if (pick < 16)
            begin
                l = $urandom;
                r = $urandom;
                send_item(ACT_SAMPLE, l, r, $urandom, $urandom, 31'($urandom));
            end
            else
            begin
                send_item(action_t'($urandom_range(1, 3)), $urandom, $urandom,
                          ($urandom_range(0, 1) != 0) ? $urandom :
                          32'($signed($urandom_range(0, 2000000)) - 1000000),
                          $urandom,
                          ($urandom_range(0, 3) == 0) ? 31'($urandom) : rand_heading());
            end
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();

        // Typical wheel constants.
        write_reg(ADDR_DIST, 32'h0000_4000 + ($urandom & 32'hffff));
        write_reg(ADDR_RAD, 32'h0010_0000 + ($urandom & 32'hfffff));
        test_random_drive(180);
        hold_ready = 1;
        drain_results();
        hold_ready = 0;

        // Fully random constants.
        write_reg(ADDR_DIST, $urandom);
        write_reg(ADDR_RAD, $urandom);
        test_random_drive(180);
        drain_results();

        // Zero constants freeze the pose on samples.
        write_reg(ADDR_DIST, 32'd0);
        write_reg(ADDR_RAD, 32'd0);
        test_random_drive(40);
        drain_results();

        write_reg(ADDR_DIST, $urandom);
        write_reg(ADDR_RAD, $urandom | 32'h8000_0000);
        test_random_drive(130);
        drain_results();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
